>>> rtl/mbp_pkg.sv
// mbp_pkg: shared types, function codes and sizing constants of the MSB-first bit packer.
// No dependencies; every other file imports it.
`default_nettype none
package mbp_pkg;

	// function codes of an input item
	localparam logic FUNC_APPEND = 1'b0;
	localparam logic FUNC_FINISH = 1'b1;

	localparam int MAX_FIELD_WIDTH = 32;
	localparam int VALUE_BITS      = 32;
	localparam int WIDTH_LIMIT     = (MAX_FIELD_WIDTH < VALUE_BITS) ? MAX_FIELD_WIDTH
	                                                                 : VALUE_BITS;
	localparam int PEND_BITS       = 7;
	localparam int ACC_BITS        = VALUE_BITS + PEND_BITS;
	localparam int MAX_BYTES       = (VALUE_BITS + PEND_BITS) / 8;
	localparam int CNT_BITS        = $clog2(MAX_BYTES + 1);
	localparam int TOTAL_BITS      = $clog2(ACC_BITS + 1);

	typedef struct packed {
		logic        func;
		logic [31:0] field_value;
		logic [5:0]  field_width;
	} item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic [3:0] bits_in_byte;
		logic       end_of_stream;
	} result_t;

	// bytes one item produces; bytes[0] goes out first
	typedef struct packed {
		logic [MAX_BYTES-1:0][7:0] bytes;
		logic [CNT_BITS-1:0]       cnt;
		logic                      fin;
		logic [3:0]                tail_bits;
	} group_t;

endpackage
`default_nettype wire

>>> rtl/mbp_ifs.sv
// mbp_item_if / mbp_result_if: valid-ready channels of the bit packer.
// Depends on mbp_pkg for the payload types.
`default_nettype none
interface mbp_item_if;
	import mbp_pkg::*;
	logic  valid;
	logic  ready;
	item_t data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface mbp_result_if;
	import mbp_pkg::*;
	logic    valid;
	logic    ready;
	result_t data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> rtl/mbp_pack.sv
// mbp_pack: pending remainder register and the single-pass packing logic.
// Depends on mbp_pkg.
`default_nettype none
module mbp_pack (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           accept,
	input  wire mbp_pkg::item_t item_data,
	output mbp_pkg::group_t     grp
);
	import mbp_pkg::*;

	logic [PEND_BITS-1:0]  pend_q;
	logic [2:0]            pend_cnt_q;
	logic [PEND_BITS-1:0]  pend_next;
	logic [2:0]            pend_cnt_next;
	logic [5:0]            w_sat;
	logic [VALUE_BITS-1:0] val_masked;
	logic [ACC_BITS-1:0]   acc;
	logic [ACC_BITS-1:0]   word;
	logic [TOTAL_BITS-1:0] total;

	always_comb begin
		w_sat = (item_data.field_width > 6'(WIDTH_LIMIT)) ? 6'(WIDTH_LIMIT)
		                                                  : item_data.field_width;
		val_masked = item_data.field_value & ~({VALUE_BITS{1'b1}} << w_sat);
		acc   = ({{VALUE_BITS{1'b0}}, pend_q} << w_sat) | {{PEND_BITS{1'b0}}, val_masked};
		total = TOTAL_BITS'(pend_cnt_q) + TOTAL_BITS'(w_sat);
		// left-align the stream so completed bytes sit at the top
		word  = acc << (TOTAL_BITS'(ACC_BITS) - total);
	end

	always_comb begin
		grp = '0;
		if (item_data.func == FUNC_FINISH) begin
			grp.bytes[0]  = 8'(pend_q);
			grp.cnt       = CNT_BITS'(1);
			grp.fin       = 1'b1;
			grp.tail_bits = {1'b0, pend_cnt_q};
			pend_next     = '0;
			pend_cnt_next = '0;
		end else begin
			for (int k = 0; k < MAX_BYTES; k++) begin
				grp.bytes[k] = word[ACC_BITS-1-8*k -: 8];
			end
			grp.cnt       = CNT_BITS'(total >> 3);
			pend_cnt_next = total[2:0];
			pend_next     = acc[PEND_BITS-1:0] & ~({PEND_BITS{1'b1}} << pend_cnt_next);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q     <= '0;
			pend_cnt_q <= '0;
		end else if (accept) begin
			pend_q     <= pend_next;
			pend_cnt_q <= pend_cnt_next;
		end
	end

endmodule
`default_nettype wire

>>> rtl/mbp_emit.sv
// mbp_emit: group register and output register; sends one byte per beat.
// Depends on mbp_pkg and mbp_result_if.
`default_nettype none
module mbp_emit (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            load,
	input  wire mbp_pkg::group_t grp,
	output logic                 can_load,
	mbp_result_if.source         result
);
	import mbp_pkg::*;

	group_t              grp_s1;
	logic [CNT_BITS-1:0] left_q;
	logic                out_valid_q;
	result_t             out_data_q;
	logic                move;
	logic                last;

	assign move     = (left_q != '0) && (!out_valid_q || result.ready);
	assign can_load = (left_q == '0) || ((left_q == CNT_BITS'(1)) && move);
	assign last     = grp_s1.fin && (left_q == CNT_BITS'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q <= '0;
		end else if (load) begin
			left_q <= grp.cnt;
		end else if (move) begin
			left_q <= left_q - CNT_BITS'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			grp_s1 <= grp;
		end else if (move) begin
			grp_s1.bytes <= grp_s1.bytes >> 8;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (move) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (move) begin
			out_data_q.out_byte      <= grp_s1.bytes[0];
			out_data_q.bits_in_byte  <= last ? grp_s1.tail_bits : 4'd8;
			out_data_q.end_of_stream <= last;
		end
	end

	assign result.valid = out_valid_q;
	assign result.data  = out_data_q;

`ifndef SYNTH
	a_load_reaches_out: assert property (@(posedge clk) disable iff (!arst_n)
		load && (grp.cnt != '0) && !out_valid_q |=> ##1 out_valid_q)
		else $error("loaded group did not reach the output register");
	a_stall_holds_group: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !result.ready && !load |=> left_q == $past(left_q))
		else $error("group advanced while output stalled");
	a_end_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		move && grp_s1.fin |-> left_q == CNT_BITS'(1))
		else $error("end beat is not the last of its group");
	a_full_unless_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_data_q.end_of_stream |-> out_data_q.bits_in_byte == 4'd8)
		else $error("non-final beat carries a partial byte");
`endif

endmodule
`default_nettype wire

>>> rtl/msb_first_bit_packer.sv
// msb_first_bit_packer: top level; packs 0..32-bit fields MSB first into bytes.
// Depends on mbp_pkg, mbp_ifs, mbp_pack and mbp_emit.
// Path: an accepted item's bytes pass the group register, then the output register.
// Flow: an item emits N bytes (0..4); the next is taken when the group register
//   is empty or its last byte goes; it sends one byte per cycle unless stalled.
// Reset: arst_n clears the remainder, group byte count and output valid flag.
`default_nettype none
module msb_first_bit_packer (
	input  wire logic  clk,
	input  wire logic  arst_n,
	mbp_item_if.sink   item,
	mbp_result_if.source result
);
	import mbp_pkg::*;

	logic   accept;
	logic   can_load;
	group_t grp;

	// Take a new item whenever the group register is empty or sends its
	// last byte in this cycle; an item that emits nothing just updates the
	// remainder.
	assign item.ready = can_load;
	assign accept     = item.valid && can_load;

	// Compute the completed bytes and the next remainder in one pass.
	mbp_pack u_pack (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.item_data (item.data),
		.grp       (grp)
	);

	// Hold the group and advance it one byte per beat into the output register.
	mbp_emit u_emit (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (accept),
		.grp      (grp),
		.can_load (can_load),
		.result   (result)
	);

endmodule
`default_nettype wire
